[rtl/cpd_pkg.sv]
`timescale 1ns / 1ps

package cpd_pkg;

    localparam int COIL_COUNT    = 12;
    localparam int PWM_MAX       = 1000;
    localparam int COIL_IW       = (COIL_COUNT > 1) ? $clog2(COIL_COUNT) : 1;
    localparam int ONE_Q14       = 16384;
    localparam int OVERPOWER_Q14 = 13107;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] CMD_SET_POWER   = 3'd0;
    localparam logic [2:0] CMD_TICK        = 3'd1;
    localparam logic [2:0] CMD_START_TEST  = 3'd2;
    localparam logic [2:0] CMD_STOP_TEST   = 3'd3;
    localparam logic [2:0] CMD_SAFETY      = 3'd4;
    localparam logic [2:0] CMD_RESET_FAULT = 3'd5;

    localparam logic [2:0] CFG_TEST_COIL    = 3'd0;
    localparam logic [2:0] CFG_TEST_START   = 3'd1;
    localparam logic [2:0] CFG_TEST_END     = 3'd2;
    localparam logic [2:0] CFG_TEST_STEP    = 3'd3;
    localparam logic [2:0] CFG_STEP_TICKS   = 3'd4;
    localparam logic [2:0] CFG_OC_LIMIT     = 3'd5;

    localparam logic [1:0] REASON_NONE        = 2'd0;
    localparam logic [1:0] REASON_OVERPOWER   = 2'd1;
    localparam logic [1:0] REASON_OVERCURRENT = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SET,
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_SAFETY,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic [3:0]         test_coil;
        logic signed [15:0] test_start;
        logic signed [15:0] test_end;
        logic signed [15:0] test_step;
        logic [15:0]        step_ticks;
        logic [15:0]        overcurrent_limit;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  coil;
        logic        coil_ok;
        logic        neg;
        logic [14:0] mag;
        logic        over_cur;
    } item_t;

    typedef struct packed {
        logic        neg;
        logic [14:0] mag;
    } drive_t;

    // Clamp a signed power value to +-1.0 and split it into sign and magnitude.
    function automatic drive_t clamp_power(input logic signed [17:0] p);
        drive_t             d;
        logic signed [17:0] neg_p;
        neg_p = -p;
        if (p > 18'sd16384) begin
            d.neg = 1'b0;
            d.mag = 15'(ONE_Q14);
        end else if (p < -18'sd16384) begin
            d.neg = 1'b1;
            d.mag = 15'(ONE_Q14);
        end else if (p < 18'sd0) begin
            d.neg = 1'b1;
            d.mag = neg_p[14:0];
        end else begin
            d.neg = 1'b0;
            d.mag = p[14:0];
        end
        return d;
    endfunction

    function automatic logic [15:0] pwm_compare(input logic [14:0] mag);
        logic [30:0] prod;
        prod = 31'(mag) * 31'(PWM_MAX);
        return prod[29:14];
    endfunction

endpackage

[rtl/cpd_front.sv]
`timescale 1ns / 1ps

module cpd_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_command,
    input  logic [3:0]         s_coil,
    input  logic signed [15:0] s_power,
    input  logic [15:0]        s_current_sample,
    input  cpd_pkg::cfg_t      cfg,
    input  logic               queue_full,
    output logic               push,
    output cpd_pkg::item_t     push_item
);

    logic [3:0]      target;
    cpd_pkg::drive_t req;

    always_comb begin
        req = cpd_pkg::clamp_power({{2{s_power[15]}}, s_power});
        push_item          = '0;
        push_item.neg      = req.neg;
        push_item.mag      = req.mag;
        push_item.over_cur = (s_current_sample > cfg.overcurrent_limit);
        target             = s_coil;
        unique case (s_command)
            cpd_pkg::CMD_SET_POWER:   push_item.op = cpd_pkg::OP_SET;
            cpd_pkg::CMD_TICK: begin
                push_item.op = cpd_pkg::OP_TICK;
                target       = cfg.test_coil;
            end
            cpd_pkg::CMD_START_TEST: begin
                push_item.op = cpd_pkg::OP_START;
                target       = cfg.test_coil;
            end
            cpd_pkg::CMD_STOP_TEST: begin
                push_item.op = cpd_pkg::OP_STOP;
                target       = cfg.test_coil;
            end
            cpd_pkg::CMD_SAFETY:      push_item.op = cpd_pkg::OP_SAFETY;
            cpd_pkg::CMD_RESET_FAULT: push_item.op = cpd_pkg::OP_CLEAR;
            default:                  push_item.op = cpd_pkg::OP_NONE;
        endcase
        push_item.coil    = target;
        push_item.coil_ok = ({1'b0, target} < 5'(cpd_pkg::COIL_COUNT));
    end

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

endmodule

[rtl/cpd_fifo.sv]
`timescale 1ns / 1ps

module cpd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cpd_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output cpd_pkg::item_t pop_item,
    output logic           empty
);

    cpd_pkg::item_t                     mem_reg [cpd_pkg::QUEUE_DEPTH];
    logic [cpd_pkg::QUEUE_AW-1:0]       wr_ptr_reg;
    logic [cpd_pkg::QUEUE_AW-1:0]       rd_ptr_reg;
    logic [cpd_pkg::QUEUE_AW:0]         count_reg;
    logic [cpd_pkg::QUEUE_AW:0]         count_next;

    assign full     = (count_reg == (cpd_pkg::QUEUE_AW+1)'(cpd_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/cpd_back.sv]
`timescale 1ns / 1ps

module cpd_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  cpd_pkg::cfg_t  cfg,
    input  logic           item_valid,
    input  cpd_pkg::item_t item,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [3:0]     m_out_coil,
    output logic           m_drive_update,
    output logic           m_direction,
    output logic [15:0]    m_compare,
    output logic [14:0]    m_magnitude,
    output logic           m_faulty,
    output logic [1:0]     m_fault_cause,
    output logic           m_test_running
);

    logic [14:0] mag_reg    [cpd_pkg::COIL_COUNT];
    logic        fault_reg  [cpd_pkg::COIL_COUNT];
    logic [1:0]  reason_reg [cpd_pkg::COIL_COUNT];

    logic               ramp_active_reg, ramp_active_next;
    logic [15:0]        tick_reg, tick_next;
    logic signed [17:0] ramp_reg, ramp_next;
    logic               m_valid_reg;

    logic [cpd_pkg::COIL_IW-1:0] idx;
    logic [14:0]        cur_mag, new_mag;
    logic               cur_fault, new_fault;
    logic [1:0]         cur_reason, new_reason;
    logic               drv_en;
    cpd_pkg::drive_t    drv_val;
    logic [16:0]        tick_cnt;
    logic [15:0]        tick_lim;
    logic signed [17:0] step_ext, end_ext, ramp_sum;
    logic               ramp_keep;
    logic               upd;
    logic               dir;
    logic [15:0]        cmp_val;

    assign idx        = item.coil[cpd_pkg::COIL_IW-1:0];
    assign cur_mag    = mag_reg[idx];
    assign cur_fault  = fault_reg[idx];
    assign cur_reason = reason_reg[idx];

    assign step_ext = {{2{cfg.test_step[15]}}, cfg.test_step};
    assign end_ext  = {{2{cfg.test_end[15]}}, cfg.test_end};
    assign ramp_sum = ramp_reg + step_ext;
    assign tick_cnt = {1'b0, tick_reg} + 17'd1;
    assign tick_lim = (cfg.step_ticks == '0) ? 16'd1 : cfg.step_ticks;
    assign ramp_keep = ((step_ext > 18'sd0) && (ramp_sum <= end_ext))
                    || ((step_ext < 18'sd0) && (ramp_sum >= end_ext));

    assign pop     = item_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        new_mag          = cur_mag;
        new_fault        = cur_fault;
        new_reason       = cur_reason;
        drv_en           = 1'b0;
        drv_val          = '0;
        ramp_active_next = ramp_active_reg;
        tick_next        = tick_reg;
        ramp_next        = ramp_reg;
        case (item.op)
            cpd_pkg::OP_SET: begin
                drv_en  = 1'b1;
                drv_val = {item.neg, item.mag};
            end
            cpd_pkg::OP_TICK: begin
                if (ramp_active_reg) begin
                    if (tick_cnt >= {1'b0, tick_lim}) begin
                        tick_next = '0;
                        ramp_next = ramp_sum;
                        drv_en    = 1'b1;
                        if (ramp_keep) begin
                            drv_val = cpd_pkg::clamp_power(ramp_sum);
                        end else begin
                            ramp_active_next = 1'b0;
                        end
                    end else begin
                        tick_next = tick_cnt[15:0];
                    end
                end
            end
            cpd_pkg::OP_START: begin
                ramp_active_next = 1'b1;
                tick_next        = '0;
                ramp_next        = {{2{cfg.test_start[15]}}, cfg.test_start};
            end
            cpd_pkg::OP_STOP: begin
                ramp_active_next = 1'b0;
            end
            cpd_pkg::OP_SAFETY: begin
                if (cur_mag > 15'(cpd_pkg::OVERPOWER_Q14)) begin
                    if (!cur_fault) begin
                        new_fault  = 1'b1;
                        new_reason = cpd_pkg::REASON_OVERPOWER;
                    end
                end else if (cur_fault && (cur_reason == cpd_pkg::REASON_OVERPOWER)) begin
                    new_fault = 1'b0;
                end
                // Overcurrent wins over the overpower result and forces the drive off.
                if (item.over_cur) begin
                    new_fault  = 1'b1;
                    new_reason = cpd_pkg::REASON_OVERCURRENT;
                    drv_en     = 1'b1;
                end
            end
            cpd_pkg::OP_CLEAR: begin
                new_fault  = 1'b0;
                new_reason = cpd_pkg::REASON_NONE;
            end
            default: begin
            end
        endcase
        if (drv_en) begin
            new_mag = drv_val.mag;
        end
        upd     = drv_en && item.coil_ok;
        dir     = upd && drv_val.neg;
        cmp_val = upd ? cpd_pkg::pwm_compare(drv_val.mag) : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cpd_pkg::COIL_COUNT; i++) begin
                mag_reg[i]    <= '0;
                fault_reg[i]  <= 1'b0;
                reason_reg[i] <= cpd_pkg::REASON_NONE;
            end
            ramp_active_reg <= 1'b0;
            tick_reg        <= '0;
            ramp_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (pop) begin
                if (item.coil_ok) begin
                    mag_reg[idx]    <= new_mag;
                    fault_reg[idx]  <= new_fault;
                    reason_reg[idx] <= new_reason;
                end
                ramp_active_reg <= ramp_active_next;
                tick_reg        <= tick_next;
                ramp_reg        <= ramp_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_out_coil     <= item.coil;
            m_drive_update <= upd;
            m_direction    <= dir;
            m_compare      <= cmp_val;
            m_magnitude    <= item.coil_ok ? new_mag : 15'd0;
            m_faulty       <= item.coil_ok && new_fault;
            m_fault_cause  <= item.coil_ok ? new_reason : cpd_pkg::REASON_NONE;
            m_test_running <= ramp_active_next;
        end
    end

endmodule

[rtl/coil_pwm_driver_ramp_fault.sv]
`timescale 1ns / 1ps

// Driver for a bank of twelve bipolar coils, one command per transfer on the s_ channel and
// exactly one status transfer per command on the m_ channel. The front end decodes each
// command, clamps the requested Q2.14 power and compares the current sample, then queues it;
// the back end updates the per-coil table and the ramp state and registers the result. An
// accepted command is written into the queue, and its result is registered in the back end
// output register once popped; the block sustains one command per clock while m_ready
// holds, set by the read-modify-write of the coil table. Configuration writes on the cfg_
// channel are always accepted and must be made only while no command is in flight.
module coil_pwm_driver_ramp_fault (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_command,
    input  logic [3:0]         s_coil,
    input  logic signed [15:0] s_power,
    input  logic [15:0]        s_current_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_out_coil,
    output logic               m_drive_update,
    output logic               m_direction,
    output logic [15:0]        m_compare,
    output logic [14:0]        m_magnitude,
    output logic               m_faulty,
    output logic [1:0]         m_fault_cause,
    output logic               m_test_running
);

    cpd_pkg::cfg_t  cfg_reg;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;
    cpd_pkg::item_t push_item;
    cpd_pkg::item_t pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.test_coil         <= 4'd0;
            cfg_reg.test_start        <= 16'sd0;
            cfg_reg.test_end          <= 16'sd0;
            cfg_reg.test_step         <= 16'sd0;
            cfg_reg.step_ticks        <= 16'd1000;
            cfg_reg.overcurrent_limit <= 16'd5000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                cpd_pkg::CFG_TEST_COIL:  cfg_reg.test_coil         <= cfg_data[3:0];
                cpd_pkg::CFG_TEST_START: cfg_reg.test_start        <= cfg_data;
                cpd_pkg::CFG_TEST_END:   cfg_reg.test_end          <= cfg_data;
                cpd_pkg::CFG_TEST_STEP:  cfg_reg.test_step         <= cfg_data;
                cpd_pkg::CFG_STEP_TICKS: cfg_reg.step_ticks        <= cfg_data;
                cpd_pkg::CFG_OC_LIMIT:   cfg_reg.overcurrent_limit <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    cpd_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_coil           (s_coil),
        .s_power          (s_power),
        .s_current_sample (s_current_sample),
        .cfg              (cfg_reg),
        .queue_full       (queue_full),
        .push             (push),
        .push_item        (push_item)
    );

    cpd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    cpd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .item_valid     (!queue_empty),
        .item           (pop_item),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_coil     (m_out_coil),
        .m_drive_update (m_drive_update),
        .m_direction    (m_direction),
        .m_compare      (m_compare),
        .m_magnitude    (m_magnitude),
        .m_faulty       (m_faulty),
        .m_fault_cause  (m_fault_cause),
        .m_test_running (m_test_running)
    );

endmodule
